// ----- hw/rtl/sequence_track_event_scanner_core_assert.svh -----
// assertion macros for the sequence track event scanner
`ifndef SEQUENCE_TRACK_EVENT_SCANNER_CORE_ASSERT_SVH
`define SEQUENCE_TRACK_EVENT_SCANNER_CORE_ASSERT_SVH

// concurrent check on an explicit clock and active-low reset
`define STES_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// concurrent check on the usual clk_i and rst_ni
`define STES_ASSERT(label, prop, msg) \
  `STES_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- hw/rtl/stes_pkg.sv -----
// types, constants and helper functions of the track event scanner
package stes_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned LengthW = 21;
  localparam int unsigned CountW  = 19;
  localparam int unsigned ParamW  = 3;

  localparam logic [LengthW-1:0] MaxTrackBytes = LengthW'(1048576);
  localparam logic [CountW-1:0]  MaxEvents     = CountW'(262144);

  // stored parse phase
  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_STATUS   = 3'd1,
    PH_NOTE     = 3'd2,
    PH_VAR_TIME = 3'd3,
    PH_FIXED    = 3'd4,
    PH_VAR_DUR  = 3'd5,
    PH_EXTRA    = 3'd6,
    PH_PARAMS   = 3'd7
  } phase_e;

  // per-item result code
  typedef enum logic [StatusW-1:0] {
    ST_INSIDE = 3'd0,
    ST_DONE   = 3'd1,
    ST_END    = 3'd2,
    ST_ERROR  = 3'd3,
    ST_IDLE   = 3'd4
  } scan_status_e;

  // where the parser goes after one byte: either the event is complete or a phase
  typedef struct packed {
    logic   done;
    phase_e phase;
  } next_t;

  localparam next_t NextDone = '{done: 1'b1, phase: PH_IDLE};

  function automatic next_t go(input phase_e ph);
    next_t r;
    r.done  = 1'b0;
    r.phase = ph;
    return r;
  endfunction

  // parameter byte count of a control code
  function automatic logic [ParamW-1:0] param_count(input logic [4:0] code);
    logic [ParamW-1:0] n;
    case (code) inside
      [5'd1:5'd6], 5'd9, [5'd13:5'd14], [5'd16:5'd21]: begin
        n = ParamW'(1);
      end
      5'd7, 5'd10: begin
        n = ParamW'(2);
      end
      5'd8: begin
        n = ParamW'(4);
      end
      default: begin
        n = '0;
      end
    endcase
    return n;
  endfunction

  // optional timing field selected by bits 6:5 of the status
  function automatic next_t timing_next(input logic [ByteW-1:0] s, input next_t otherwise);
    next_t r;
    case (s[6:5])
      2'b10:   r = go(PH_VAR_TIME);
      2'b11:   r = go(PH_FIXED);
      default: r = otherwise;
    endcase
    return r;
  endfunction

  function automatic next_t note_after_dur(input logic vel);
    return vel ? go(PH_EXTRA) : NextDone;
  endfunction

  function automatic next_t note_after_timing(input logic [ByteW-1:0] s, input logic vel);
    return (s[4:0] == 5'h1f) ? go(PH_VAR_DUR) : note_after_dur(vel);
  endfunction

  function automatic next_t after_timing(input logic [ByteW-1:0] s, input logic vel);
    return s[7] ? NextDone : note_after_timing(s, vel);
  endfunction

endpackage

// ----- hw/rtl/stes_if.sv -----
// item channels of the track event scanner
interface stes_in_if;
  logic                          valid;
  logic                          ready;
  logic [stes_pkg::ByteW-1:0]    data_byte;
  logic                          track_start;
  logic                          region_last;

  modport source (output valid, output data_byte, output track_start, output region_last,
                  input ready);
  modport sink   (input valid, input data_byte, input track_start, input region_last,
                  output ready);
endinterface

interface stes_out_if;
  logic                          valid;
  logic                          ready;
  logic [stes_pkg::StatusW-1:0]  scan_status;
  logic [stes_pkg::LengthW-1:0]  track_length;
  logic [stes_pkg::CountW-1:0]   event_count;

  modport source (output valid, output scan_status, output track_length, output event_count,
                  input ready);
  modport sink   (input valid, input scan_status, input track_length, input event_count,
                  output ready);
endinterface

// ----- hw/rtl/sequence_track_event_scanner_core.sv -----
// track event scanner: byte-serial parser of music sequence track events
// The scanner takes one track byte per item and returns one result item for each:
// a status (inside event, event complete, track end, error, idle byte ignored), the
// running byte count of the track and the number of completed events. A byte with
// track_start set clears all state and is parsed as a status byte. After a track
// end or an error the scanner ignores bytes until the next track_start. Throughput
// is one item per clock cycle when neither side stalls; each item goes through an
// input register and then a result register, and the parse state is updated as the
// item moves from the input register into the result register. Either side may
// stall: the input register takes a new item whenever it is empty, or the result
// register is free or being drained in the same cycle.

`include "sequence_track_event_scanner_core_assert.svh"

module sequence_track_event_scanner_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  stes_in_if.sink      in_i,
  stes_out_if.source   out_o
);

  // input register
  logic                          in_valid_q;
  logic [stes_pkg::ByteW-1:0]    in_byte_q;
  logic                          in_start_q;
  logic                          in_last_q;

  // result register
  logic                          out_valid_q;
  stes_pkg::scan_status_e        out_status_q;
  logic [stes_pkg::LengthW-1:0]  out_length_q;
  logic [stes_pkg::CountW-1:0]   out_count_q;

  // parse state
  stes_pkg::phase_e              phase_q, phase_d;
  logic [stes_pkg::ByteW-1:0]    held_q, held_d;
  logic                          vel_q, vel_d;
  logic [stes_pkg::ParamW-1:0]   par_q, par_d;
  logic                          v2_q, v2_d;
  logic [stes_pkg::LengthW-1:0]  bc_q, bc_d;
  logic [stes_pkg::CountW-1:0]   ec_q, ec_d;

  // state as seen by the byte in the input register (track start clears it)
  stes_pkg::phase_e              ph_cur;
  logic [stes_pkg::ByteW-1:0]    held_cur;
  logic                          vel_cur;
  logic [stes_pkg::ParamW-1:0]   par_cur;
  logic                          v2_cur;
  logic [stes_pkg::LengthW-1:0]  bc_cur;
  logic [stes_pkg::CountW-1:0]   ec_cur;

  stes_pkg::scan_status_e        st_d;
  stes_pkg::next_t               nx;
  logic                          last;
  logic                          is_end;
  logic                          adv;

  // the input register moves on when the result register is free or drains now
  assign adv        = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || adv;

  assign ph_cur   = in_start_q ? stes_pkg::PH_STATUS : phase_q;
  assign held_cur = in_start_q ? '0 : held_q;
  assign vel_cur  = in_start_q ? 1'b0 : vel_q;
  assign par_cur  = in_start_q ? '0 : par_q;
  assign v2_cur   = in_start_q ? 1'b0 : v2_q;
  assign bc_cur   = in_start_q ? '0 : bc_q;
  assign ec_cur   = in_start_q ? '0 : ec_q;

  // end-of-track control: control status with code 0
  assign is_end = held_d[7] && (held_d[6:5] != 2'b01) && (held_d[4:0] == 5'd0);

  always_comb begin
    phase_d = ph_cur;
    held_d  = held_cur;
    vel_d   = vel_cur;
    par_d   = par_cur;
    v2_d    = v2_cur;
    bc_d    = bc_cur;
    ec_d    = ec_cur;
    nx      = stes_pkg::go(stes_pkg::PH_IDLE);
    st_d    = stes_pkg::ST_IDLE;
    last    = 1'b0;

    if (ph_cur != stes_pkg::PH_IDLE) begin
      // byte counter saturates at the track byte cap
      if (bc_cur < stes_pkg::MaxTrackBytes) begin
        bc_d = bc_cur + stes_pkg::LengthW'(1);
      end
      last = in_last_q || (bc_d >= stes_pkg::MaxTrackBytes);

      case (ph_cur)
        stes_pkg::PH_STATUS: begin
          held_d = in_byte_q;
          vel_d  = 1'b0;
          v2_d   = 1'b0;
          if (!in_byte_q[7]) begin
            nx = stes_pkg::go(stes_pkg::PH_NOTE);
          end else if (in_byte_q[6:5] == 2'b01) begin
            // relative note: single byte event
            nx = stes_pkg::NextDone;
          end else begin
            par_d = stes_pkg::param_count(in_byte_q[4:0]);
            nx    = (par_d != '0) ? stes_pkg::go(stes_pkg::PH_PARAMS)
                                  : stes_pkg::timing_next(in_byte_q, stes_pkg::NextDone);
          end
        end
        stes_pkg::PH_NOTE: begin
          // note byte top bit asks for an extra byte at the end
          vel_d = in_byte_q[7];
          nx    = stes_pkg::timing_next(held_cur, stes_pkg::note_after_timing(held_cur, vel_d));
        end
        stes_pkg::PH_VAR_TIME, stes_pkg::PH_VAR_DUR: begin
          // a variable field has a second byte when the first has its top bit set, unless the track limit cuts it short
          if (!v2_cur && in_byte_q[7] && !last) begin
            v2_d = 1'b1;
            nx   = stes_pkg::go(ph_cur);
          end else begin
            v2_d = 1'b0;
            nx   = (ph_cur == stes_pkg::PH_VAR_TIME) ? stes_pkg::after_timing(held_cur, vel_cur)
                                                      : stes_pkg::note_after_dur(vel_cur);
          end
        end
        stes_pkg::PH_FIXED: begin
          nx = stes_pkg::after_timing(held_cur, vel_cur);
        end
        stes_pkg::PH_EXTRA: begin
          nx = stes_pkg::NextDone;
        end
        stes_pkg::PH_PARAMS: begin
          if (par_cur != '0) begin
            par_d = par_cur - stes_pkg::ParamW'(1);
          end
          nx = (par_d != '0) ? stes_pkg::go(stes_pkg::PH_PARAMS)
                             : stes_pkg::timing_next(held_cur, stes_pkg::NextDone);
        end
        default: begin
          nx = stes_pkg::NextDone;
        end
      endcase

      if (nx.done) begin
        // event count saturates at the event cap
        if (ec_cur < stes_pkg::MaxEvents) begin
          ec_d = ec_cur + stes_pkg::CountW'(1);
        end
        if (is_end) begin
          st_d    = stes_pkg::ST_END;
          phase_d = stes_pkg::PH_IDLE;
        end else if (last || (ec_d >= stes_pkg::MaxEvents)) begin
          st_d    = stes_pkg::ST_ERROR;
          phase_d = stes_pkg::PH_IDLE;
        end else begin
          st_d    = stes_pkg::ST_DONE;
          phase_d = stes_pkg::PH_STATUS;
        end
      end else if (last) begin
        // ran out of region inside an event
        st_d    = stes_pkg::ST_ERROR;
        phase_d = stes_pkg::PH_IDLE;
      end else begin
        st_d    = stes_pkg::ST_INSIDE;
        phase_d = nx.phase;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q  <= in_i.data_byte;
      in_start_q <= in_i.track_start;
      in_last_q  <= in_i.region_last;
    end
  end

  // parse state, updated once per item as it enters the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= stes_pkg::PH_IDLE;
      held_q  <= '0;
      vel_q   <= 1'b0;
      par_q   <= '0;
      v2_q    <= 1'b0;
      bc_q    <= '0;
      ec_q    <= '0;
    end else if (adv) begin
      phase_q <= phase_d;
      held_q  <= held_d;
      vel_q   <= vel_d;
      par_q   <= par_d;
      v2_q    <= v2_d;
      bc_q    <= bc_d;
      ec_q    <= ec_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_status_q <= st_d;
      out_length_q <= bc_d;
      out_count_q  <= ec_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.scan_status  = out_status_q;
  assign out_o.track_length = out_length_q;
  assign out_o.event_count  = out_count_q;

  // a pending second variable byte only lives in a variable field phase
  `STES_ASSERT(a_v2_phase, v2_q |-> (phase_q == stes_pkg::PH_VAR_TIME || phase_q == stes_pkg::PH_VAR_DUR), "second byte flag outside variable field")
  // counters never pass their caps
  `STES_ASSERT(a_bc_cap, bc_q <= stes_pkg::MaxTrackBytes, "byte counter above cap")
  `STES_ASSERT(a_ec_cap, ec_q <= stes_pkg::MaxEvents, "event counter above cap")
  // a completed event leaves the parser waiting for the next status byte
  `STES_ASSERT(a_done_next, (adv && st_d == stes_pkg::ST_DONE) |=> (phase_q == stes_pkg::PH_STATUS), "no status phase after event")

endmodule
